// ===== design/ghgc_pkg.sv =====
`timescale 1ns / 1ps
package ghgc_pkg;

  localparam int COORD_W    = 16;
  localparam int MODE_W     = 2;
  localparam int IN_TDATA_W = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int ROW_OUT_W  = 7;
  localparam int COL_OUT_W  = 6;
  localparam int SPAN_W     = 16;
  localparam int THR_W      = 16;

  localparam logic [THR_W-1:0] THR_RESET = 16'd150;

  localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACCUM    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd2;

  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic div_en;
    logic rd_en;
    logic sweep_en;
    logic finish;
  } ghgc_cmd_t;

  typedef struct packed {
    logic mode_clear;
    logic sweep_last;
    logic out_free;
  } ghgc_sts_t;

endpackage

// ===== design/grid_height_ground_classifier.sv =====
`timescale 1ns / 1ps
// Steps from an input transfer to the result on m_tvalid: multiply, quotient
// and address, cell read, update; a new point is taken only after the last result is registered.
// A clear item sweeps the cell store through its single write port, one cell a
// cycle, and then gives its result.
// Reset (rst, synchronous) sets the threshold to 150 and runs the same clearing
// sweep over every cell, with s_tready low, before the first point.
module grid_height_ground_classifier #(
  parameter int GRID_ROWS      = 128,
  parameter int GRID_COLS      = 64,
  parameter int CELL_SIZE_MM   = 500,
  parameter int FRONT_RANGE_MM = 32000,
  parameter int LEFT_RANGE_MM  = 16000,
  parameter int RIGHT_RANGE_MM = 16000
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // point_x_mm [15:0], point_y_mm [31:16], point_z_mm [47:32]
  input  logic [ghgc_pkg::IN_TDATA_W-1:0]  s_tdata,
  // mode [1:0]
  input  logic [ghgc_pkg::MODE_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // in_range [0], cell_row [7:1], cell_col [13:8], cell_occupied [14],
  // height_span_mm [30:15], is_ground [31]
  output logic [ghgc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  // height_threshold_mm [15:0]
  input  logic [ghgc_pkg::THR_W-1:0]       cfg_data
);
  import ghgc_pkg::*;

  ghgc_cmd_t cmd;
  ghgc_sts_t sts;

  assign cfg_ready = 1'b1;

  ghgc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ghgc_dp #(
    .GRID_ROWS      (GRID_ROWS),
    .GRID_COLS      (GRID_COLS),
    .CELL_SIZE_MM   (CELL_SIZE_MM),
    .FRONT_RANGE_MM (FRONT_RANGE_MM),
    .LEFT_RANGE_MM  (LEFT_RANGE_MM),
    .RIGHT_RANGE_MM (RIGHT_RANGE_MM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== design/ghgc_ctrl.sv =====
`timescale 1ns / 1ps
module ghgc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  ghgc_pkg::ghgc_sts_t sts,
  output ghgc_pkg::ghgc_cmd_t cmd
);
  import ghgc_pkg::*;

  typedef enum logic [5:0] {
    S_SWEEP = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_READ  = 6'b010000,
    S_RES   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   sweep_item, sweep_item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_item <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_item <= sweep_item_next;
    end
  end

  always_comb begin
    state_next      = state;
    sweep_item_next = sweep_item;
    case (state)
      S_SWEEP: begin
        if (sts.sweep_last) begin
          state_next      = sweep_item ? S_RES : S_IDLE;
          sweep_item_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_MUL;
      end
      S_MUL: begin
        if (sts.mode_clear) begin
          state_next      = S_SWEEP;
          sweep_item_next = 1'b1;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV:  state_next = S_READ;
      S_READ: state_next = S_RES;
      S_RES: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_SWEEP;
    endcase
  end

  assign s_tready     = (state == S_IDLE);
  assign cmd.load_in  = (state == S_IDLE) && s_tvalid;
  assign cmd.mul_en   = (state == S_MUL);
  assign cmd.div_en   = (state == S_DIV);
  assign cmd.rd_en    = (state == S_READ);
  assign cmd.sweep_en = (state == S_SWEEP);
  assign cmd.finish   = (state == S_RES) && sts.out_free;

endmodule

// ===== design/ghgc_dp.sv =====
`timescale 1ns / 1ps
module ghgc_dp #(
  parameter int GRID_ROWS      = 128,
  parameter int GRID_COLS      = 64,
  parameter int CELL_SIZE_MM   = 500,
  parameter int FRONT_RANGE_MM = 32000,
  parameter int LEFT_RANGE_MM  = 16000,
  parameter int RIGHT_RANGE_MM = 16000
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ghgc_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [ghgc_pkg::MODE_W-1:0]         s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ghgc_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  input  logic [ghgc_pkg::THR_W-1:0]          cfg_data,
  input  ghgc_pkg::ghgc_cmd_t                 cmd,
  output ghgc_pkg::ghgc_sts_t                 sts
);
  import ghgc_pkg::*;

  localparam int NCELLS = GRID_ROWS * GRID_COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int RW     = $clog2(GRID_ROWS);
  localparam int CW     = $clog2(GRID_COLS);
  // numerators stay below 2^16 whenever the point is in range
  localparam int NUM_W  = 16;
  localparam int DIV_L  = $clog2(CELL_SIZE_MM);
  localparam int DIV_S  = NUM_W + DIV_L;
  localparam int MW     = NUM_W + 1;
  localparam int PW     = NUM_W + MW;
  localparam longint unsigned DIV_M =
    ((longint'(1) << DIV_S) + longint'(CELL_SIZE_MM) - 1) / longint'(CELL_SIZE_MM);
  localparam logic [MW-1:0] RECIP = MW'(DIV_M);
  localparam logic signed [17:0] FRONT_S = 18'(FRONT_RANGE_MM);
  localparam logic signed [17:0] LEFT_S  = 18'(LEFT_RANGE_MM);
  localparam logic signed [17:0] RIGHT_S = 18'(RIGHT_RANGE_MM);
  localparam logic [NUM_W-1:0] ROWS_Q = NUM_W'(GRID_ROWS);
  localparam logic [NUM_W-1:0] COLS_Q = NUM_W'(GRID_COLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
  localparam int WORD_W = 1 + 2 * COORD_W;

  // input latch
  logic signed [COORD_W-1:0] x_r, y_r, z_r;
  logic [MODE_W-1:0]         mode_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r    <= s_tdata[COORD_W-1:0];
      y_r    <= s_tdata[2*COORD_W-1:COORD_W];
      z_r    <= s_tdata[3*COORD_W-1:2*COORD_W];
      mode_r <= s_tuser;
    end
  end

  assign sts.mode_clear = (mode_r == MODE_CLEAR);

  // window test and reciprocal multiply
  logic signed [17:0] x_e, y_e, nr_full, nc_full;
  logic               area_ok;
  logic [PW-1:0]      row_prod, col_prod;
  logic               inr_pre;

  assign x_e     = {{2{x_r[COORD_W-1]}}, x_r};
  assign y_e     = {{2{y_r[COORD_W-1]}}, y_r};
  assign nr_full = FRONT_S - x_e;
  assign nc_full = LEFT_S - y_e;
  assign area_ok = (x_e < FRONT_S) && (x_e > -FRONT_S) && (y_e < LEFT_S) && (y_e > -RIGHT_S);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      inr_pre  <= area_ok;
      row_prod <= PW'(nr_full[NUM_W-1:0]) * PW'(RECIP);
      col_prod <= PW'(nc_full[NUM_W-1:0]) * PW'(RECIP);
    end
  end

  // quotient, grid bound and cell address
  logic [PW-1:0]    row_sh, col_sh;
  logic [NUM_W-1:0] row_q, col_q;
  logic             inr;
  logic [ROW_OUT_W-1:0] row_o;
  logic [COL_OUT_W-1:0] col_o;
  logic [AW-1:0]    addr;

  assign row_sh = row_prod >> DIV_S;
  assign col_sh = col_prod >> DIV_S;
  assign row_q  = row_sh[NUM_W-1:0];
  assign col_q  = col_sh[NUM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_en) begin
      inr   <= inr_pre && (row_q < ROWS_Q) && (col_q < COLS_Q);
      row_o <= row_q[ROW_OUT_W-1:0];
      col_o <= col_q[COL_OUT_W-1:0];
      addr  <= AW'(row_q[RW-1:0]) * AW'(GRID_COLS) + AW'(col_q[CW-1:0]);
    end
  end

  // cell store: {occupied, max, min}
  logic [WORD_W-1:0] cell_mem [NCELLS];
  logic [WORD_W-1:0] rd_data, wr_data;
  logic [AW-1:0]     sweep_cnt;
  logic              wr_en;

  assign sts.sweep_last = (sweep_cnt == LAST_CELL);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_en) begin
      sweep_cnt <= sts.sweep_last ? '0 : sweep_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      cell_mem[sweep_cnt] <= '0;
    end else if (wr_en) begin
      cell_mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data <= cell_mem[addr];
  end

  // update and classify
  logic                      occ_old, occ_new, item_ok, gnd;
  logic signed [COORD_W-1:0] min_old, max_old, min_new, max_new;
  logic [COORD_W:0]          diff;
  logic [SPAN_W-1:0]         span;
  logic [THR_W-1:0]          threshold;
  logic                      is_acc, is_cls;

  assign occ_old = rd_data[WORD_W-1];
  assign max_old = rd_data[2*COORD_W-1:COORD_W];
  assign min_old = rd_data[COORD_W-1:0];
  assign is_acc  = (mode_r == MODE_ACCUM);
  assign is_cls  = (mode_r == MODE_CLASSIFY);
  assign item_ok = inr && (is_acc || is_cls);

  always_comb begin
    min_new = min_old;
    max_new = max_old;
    if (is_acc) begin
      if (!occ_old) begin
        min_new = z_r;
        max_new = z_r;
      end else begin
        if (z_r < min_old) min_new = z_r;
        if (z_r > max_old) max_new = z_r;
      end
    end
  end

  assign occ_new = is_acc | occ_old;
  assign diff    = {max_new[COORD_W-1], max_new} - {min_new[COORD_W-1], min_new};
  assign span    = occ_new ? diff[SPAN_W-1:0] : '0;
  assign gnd     = is_cls && occ_new && (span < threshold);
  assign wr_data = {1'b1, max_new, min_new};
  assign wr_en   = cmd.finish && item_ok && is_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  // result register
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (item_ok) begin
        m_tdata <= {gnd, span, occ_new, col_o, row_o, 1'b1};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

// ===== design/ghgc_checker.sv =====
`timescale 1ns / 1ps
module ghgc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic [ghgc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ghgc_pkg::*;

  // the clearing sweep holds the input off right after reset
  a_sweep_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input ready during post-reset sweep");

  // one point at a time: no transfer straight after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready in the cycle after a transfer");

  // an out-of-range result carries nothing else
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_TDATA_W-1:1] == '0))
    else $error("out-of-range result with nonzero fields");

  // ground needs an in-range, occupied cell
  a_ground_occupied: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[31]) |-> (m_tdata[0] && m_tdata[14]))
    else $error("ground flag on empty or out-of-range cell");

endmodule

bind grid_height_ground_classifier ghgc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ghgc_pkg::*;

  localparam int GRID_ROWS      = 128;
  localparam int GRID_COLS      = 64;
  localparam int CELL_SIZE_MM   = 500;
  localparam int FRONT_RANGE_MM = 32000;
  localparam int LEFT_RANGE_MM  = 16000;
  localparam int RIGHT_RANGE_MM = 16000;
  localparam int NUM_CELLS      = GRID_ROWS * GRID_COLS;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int NUM_PHASES  = 5;
  localparam int PHASE_ITEMS = 260;
  localparam int HOT_CELLS   = 16;

  typedef struct packed {
    logic                 in_range;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 occ;
    logic [SPAN_W-1:0]    span;
    logic                 gnd;
  } cell_report_t;

  typedef struct packed {
    logic [MODE_W-1:0]        md;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                     typed;
    cell_report_t             want;
  } dir_row_t;

  localparam cell_report_t NO_CELL = '0;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [MODE_W-1:0]      s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [THR_W-1:0]       cfg_data;

  // predictor state
  bit                       occ_map [NUM_CELLS];
  logic signed [COORD_W-1:0] min_z  [NUM_CELLS];
  logic signed [COORD_W-1:0] max_z  [NUM_CELLS];
  logic [THR_W-1:0]          thr_mm = THR_RESET;

  cell_report_t cell_q [$];
  dir_row_t     dir_tab [$];
  int           err_count = 0;
  int           burst_left = 0;

  int hot_row    [HOT_CELLS];
  int hot_col    [HOT_CELLS];
  int hot_base   [HOT_CELLS];
  int hot_spread [HOT_CELLS];

  grid_height_ground_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic cell_report_t rep(input logic ir, input int row, input int col,
                                       input logic occ, input int span, input logic gnd);
    cell_report_t r;
    r.in_range = ir;
    r.row      = row[ROW_OUT_W-1:0];
    r.col      = col[COL_OUT_W-1:0];
    r.occ      = occ;
    r.span     = span[SPAN_W-1:0];
    r.gnd      = gnd;
    return r;
  endfunction

  // Fold one point into the cell map and report its cell as the block should.
  function automatic cell_report_t grid_cell_report(input logic [MODE_W-1:0] md,
                                                    input logic signed [COORD_W-1:0] px,
                                                    input logic signed [COORD_W-1:0] py,
                                                    input logic signed [COORD_W-1:0] pz);
    cell_report_t r;
    int x;
    int y;
    int ax;
    int row;
    int col;
    int idx;
    int span;
    r = '0;
    x = px;
    y = py;
    if (md == MODE_CLEAR) begin
      for (int i = 0; i < NUM_CELLS; i++) occ_map[i] = 1'b0;
      return r;
    end
    if (md != MODE_ACCUM && md != MODE_CLASSIFY) return r;
    ax = (x < 0) ? -x : x;
    if (!(ax < FRONT_RANGE_MM && y < LEFT_RANGE_MM && y > -RIGHT_RANGE_MM)) return r;
    row = (FRONT_RANGE_MM - x) / CELL_SIZE_MM;
    col = (LEFT_RANGE_MM - y) / CELL_SIZE_MM;
    if (row >= GRID_ROWS || col >= GRID_COLS) return r;
    idx = row * GRID_COLS + col;
    if (md == MODE_ACCUM) begin
      if (!occ_map[idx]) begin
        occ_map[idx] = 1'b1;
        min_z[idx]   = pz;
        max_z[idx]   = pz;
      end else begin
        if (pz < min_z[idx]) min_z[idx] = pz;
        if (pz > max_z[idx]) max_z[idx] = pz;
      end
    end
    span = 0;
    if (occ_map[idx]) span = int'(max_z[idx]) - int'(min_z[idx]);
    r.in_range = 1'b1;
    r.row      = row[ROW_OUT_W-1:0];
    r.col      = col[COL_OUT_W-1:0];
    r.occ      = occ_map[idx];
    r.span     = span[SPAN_W-1:0];
    r.gnd      = (md == MODE_CLASSIFY) && occ_map[idx] && (span < int'(thr_mm));
    return r;
  endfunction

  function automatic void add_dir(input logic [MODE_W-1:0] md, input int x, input int y,
                                  input int z, input logic typed, input cell_report_t want);
    dir_row_t d;
    d.md    = md;
    d.x     = x[COORD_W-1:0];
    d.y     = y[COORD_W-1:0];
    d.z     = z[COORD_W-1:0];
    d.typed = typed;
    d.want  = want;
    dir_tab.insert(dir_tab.size(), d);
  endfunction

  // Offer one point in the current burst; open a new burst when due, after a random gap that may be empty.
  task automatic send_point(input logic [MODE_W-1:0] md, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z,
                            input logic typed, input cell_report_t want);
    cell_report_t pred;
    int gap;
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      if ($urandom_range(0, 4) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(40, 150);
      end else begin
        gap        = $urandom_range(1, 7);
        burst_left = $urandom_range(1, 12);
      end
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = md;
    s_tdata  = {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = grid_cell_report(md, x, y, z);
    cell_q.insert(cell_q.size(), typed ? want : pred);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    s_tvalid   = 1'b0;
    burst_left = 0;
    while (cell_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thr_mm = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // receiver: runs of ready and stall, now and then a long free stretch
  initial begin
    bit rdy_val;
    int run_left;
    rdy_val  = 1'b0;
    run_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        if ($urandom_range(0, 5) == 0) begin
          rdy_val  = 1'b1;
          run_left = $urandom_range(30, 120);
        end else begin
          rdy_val  = ($urandom_range(0, 2) != 0);
          run_left = rdy_val ? $urandom_range(1, 20) : $urandom_range(1, 8);
        end
      end
      m_tready = rdy_val;
      run_left--;
    end
  end

  always @(posedge clk) begin
    cell_report_t want;
    cell_report_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.in_range = m_tdata[0];
      got.row      = m_tdata[7:1];
      got.col      = m_tdata[13:8];
      got.occ      = m_tdata[14];
      got.span     = m_tdata[30:15];
      got.gnd      = m_tdata[31];
      if (cell_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected, expected none, actual %h",
                 $time, m_tdata);
        err_count++;
      end else begin
        want = cell_q.pop_front();
        check_field("in_range", want.in_range, got.in_range);
        check_field("cell_row", want.row, got.row);
        check_field("cell_col", want.col, got.col);
        check_field("cell_occupied", want.occ, got.occ);
        check_field("height_span_mm", want.span, got.span);
        check_field("is_ground", want.gnd, got.gnd);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [MODE_W-1:0]        md;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic [THR_W-1:0]          thr_plan [NUM_PHASES];
    int pick;
    int h;
    int clears_left;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = MODE_CLEAR;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      occ_map[i] = 1'b0;
      min_z[i]   = '0;
      max_z[i]   = '0;
    end

    // corners, area edges, span extremes, unused mode, a clear, reset ground threshold
    add_dir(MODE_CLASSIFY, 0, 0, 0, 1'b1, rep(1, 64, 32, 0, 0, 0));
    add_dir(MODE_ACCUM, 31999, 15999, -32768, 1'b1, rep(1, 0, 0, 1, 0, 0));
    add_dir(MODE_ACCUM, 31999, 15999, 32767, 1'b1, rep(1, 0, 0, 1, 65535, 0));
    add_dir(MODE_CLASSIFY, 31999, 15999, 0, 1'b1, rep(1, 0, 0, 1, 65535, 0));
    add_dir(MODE_ACCUM, -31999, -15999, 100, 1'b1, rep(1, 127, 63, 1, 0, 0));
    add_dir(MODE_CLASSIFY, -31999, -15999, -5, 1'b1, rep(1, 127, 63, 1, 0, 1));
    add_dir(MODE_ACCUM, 32000, 0, 0, 1'b1, NO_CELL);
    add_dir(MODE_CLASSIFY, -32000, 0, 0, 1'b1, NO_CELL);
    add_dir(MODE_ACCUM, 0, 16000, 0, 1'b1, NO_CELL);
    add_dir(MODE_ACCUM, 0, -16000, 0, 1'b1, NO_CELL);
    add_dir(MODE_CLASSIFY, -32768, -32768, -32768, 1'b1, NO_CELL);
    add_dir(MODE_ACCUM, 32767, 32767, 32767, 1'b1, NO_CELL);
    add_dir(MODE_UNUSED, -1, -1, -1, 1'b1, NO_CELL);
    add_dir(MODE_ACCUM, 0, 0, 10, 1'b0, NO_CELL);
    add_dir(MODE_ACCUM, 0, 0, 159, 1'b0, NO_CELL);
    add_dir(MODE_CLASSIFY, 0, 0, 0, 1'b0, NO_CELL);
    add_dir(MODE_ACCUM, -499, -499, 160, 1'b0, NO_CELL);
    add_dir(MODE_CLASSIFY, -1, -1, 0, 1'b0, NO_CELL);
    add_dir(MODE_CLEAR, -1, -1, -1, 1'b1, NO_CELL);
    add_dir(MODE_CLASSIFY, 31999, 15999, 0, 1'b1, rep(1, 0, 0, 0, 0, 0));
    add_dir(MODE_CLASSIFY, 0, 0, 0, 1'b1, rep(1, 64, 32, 0, 0, 0));
    add_dir(MODE_ACCUM, 1, 1, -7, 1'b0, NO_CELL);

    thr_plan[0] = '0;
    thr_plan[1] = '1;
    thr_plan[2] = 16'd1;
    thr_plan[3] = 16'($urandom);
    thr_plan[4] = 16'($urandom_range(100, 400));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < dir_tab.size(); i++)
      send_point(dir_tab[i].md, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                 dir_tab[i].typed, dir_tab[i].want);

    // a clear costs a full sweep of the store, so keep them few
    clears_left = 30;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_results();
      write_threshold(thr_plan[ph]);
      for (int k = 0; k < HOT_CELLS; k++) begin
        hot_row[k]  = $urandom_range(0, GRID_ROWS - 1);
        hot_col[k]  = $urandom_range(0, GRID_COLS - 1);
        hot_base[k] = int'($urandom_range(0, 4000)) - 2000;
        case ($urandom_range(0, 2))
          0:       hot_spread[k] = 40;
          1:       hot_spread[k] = 160;
          default: hot_spread[k] = 600;
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2 && clears_left > 0) begin
          md = MODE_CLEAR;
          clears_left--;
        end else if (pick < 5)  md = MODE_UNUSED;
        else if (pick < 55)     md = MODE_ACCUM;
        else                    md = MODE_CLASSIFY;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // land in one of a few busy cells so spans build up
          h  = $urandom_range(0, HOT_CELLS - 1);
          px = 16'(FRONT_RANGE_MM - CELL_SIZE_MM * hot_row[h] - int'($urandom_range(0, 499)));
          py = 16'(LEFT_RANGE_MM - CELL_SIZE_MM * hot_col[h] - int'($urandom_range(0, 499)));
          if ($urandom_range(0, 9) == 0) pz = 16'($urandom);
          else pz = 16'(hot_base[h] + int'($urandom_range(0, hot_spread[h])));
        end else if (pick < 85) begin
          px = 16'($urandom);
          py = 16'($urandom);
          pz = 16'($urandom);
        end else begin
          px = 16'(($urandom_range(0, 1) ? -1 : 1) * (31999 + int'($urandom_range(0, 1))));
          py = 16'(($urandom_range(0, 1) ? -1 : 1) * (15999 + int'($urandom_range(0, 1))));
          pz = 16'($urandom);
        end
        send_point(md, px, py, pz, 1'b0, NO_CELL);
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
